/* src/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, b)
`define ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

/* src/flre_pkg.sv */
`default_nettype none
package flre_pkg;
    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_LINE  = 2'd1,
        OP_FILL  = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    localparam logic [1:0] COLOR_BLACK  = 2'd0;
    localparam logic [1:0] COLOR_WHITE  = 2'd1;
    localparam logic [1:0] COLOR_INVERT = 2'd2;

    localparam logic [9:0] COUNT_MAX = 10'd1023;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic [1:0] color;
        logic [1:0] page_index;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [9:0] pixels_touched;
    } result_t;
endpackage
`default_nettype wire

/* src/flre_ram.sv */
`default_nettype none
module flre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/flre_cmd_fifo.sv */
`default_nettype none
// Two-entry command queue between the front and the back end.
module flre_cmd_fifo
    import flre_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);
    cmd_t       slot_reg [2];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = slot_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            slot_reg[wptr_reg] <= in_cmd;
        end
    end
endmodule
`default_nettype wire

/* src/flre_exec.sv */
`default_nettype none
// Back end: clears the store after reset, then executes one command at a time.
// Each pixel or fill byte: read, wait, write states in turn; a byte read only reads.
module flre_exec
    import flre_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 32
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    cmd_valid,
    output logic         cmd_ready,
    input  wire cmd_t    cmd,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data,
    output logic         busy
);
    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH = PAGES * SCREEN_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_RD    = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_WR    = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CW-1:0]    addr_reg, addr_next;
    logic signed [9:0] x_reg, x_next, y_reg, y_next;
    logic signed [9:0] dx_reg, dx_next, dy_reg, dy_next, err_reg, err_next;
    logic [9:0]       cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             on_reg, on_next;
    logic [AW-1:0]    pix_addr_reg, pix_addr_next;
    logic [7:0]       mask_reg, mask_next;
    result_t          res_reg, res_next;
    logic             mv_reg, mv_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [7:0]       wdata, rdata;

    flre_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign m_valid   = mv_reg;
    assign m_data    = res_reg;
    assign cmd_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign busy      = (state_reg != ST_IDLE);

    // pixel address and on-screen test for the current point
    logic        cur_on;
    logic [AW-1:0] cur_addr;
    logic signed [10:0] e2;
    always_comb begin
        cur_on = (x_reg >= 0) && (y_reg >= 0) && (x_reg < 10'(SCREEN_WIDTH))
                 && (y_reg < 10'(SCREEN_HEIGHT)) && (cmd_reg.color != 2'd3);
        cur_addr = AW'(({22'd0, y_reg[9:3]} * SCREEN_WIDTH) + {22'd0, x_reg[XW-1:0]});
        e2 = {err_reg, 1'b0};
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        err_next      = err_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        on_next       = on_reg;
        pix_addr_next = pix_addr_reg;
        mask_next     = mask_reg;
        res_next      = res_reg;
        mv_next       = mv_reg && !m_ready;
        we            = 1'b0;
        waddr         = pix_addr_reg;
        wdata         = rdata;
        raddr         = pix_addr_reg;
        case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = addr_reg[AW-1:0];
                wdata = 8'h00;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == CW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    cmd_next  = cmd;
                    x_next    = 10'(cmd.x_start);
                    y_next    = 10'(cmd.y_start);
                    cnt_next  = 10'd0;
                    addr_next = '0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // line setup: deltas and initial error; a byte read also gets its address
                dx_next  = (cmd_reg.x_end > cmd_reg.x_start) ?
                           10'(cmd_reg.x_end - cmd_reg.x_start) :
                           10'(cmd_reg.x_start - cmd_reg.x_end);
                dy_next  = (cmd_reg.y_end > cmd_reg.y_start) ?
                           -10'(cmd_reg.y_end - cmd_reg.y_start) :
                           -10'(cmd_reg.y_start - cmd_reg.y_end);
                err_next = dx_next + dy_next;
                case (cmd_reg.opcode)
                    OP_READ: begin
                        state_next = ST_WAIT;
                        on_next = ({30'd0, cmd_reg.page_index} < 32'(PAGES)) &&
                                  (cmd_reg.x_start < 8'(SCREEN_WIDTH - 1) ||
                                   {1'b0, cmd_reg.x_start} == 9'(SCREEN_WIDTH - 1));
                        pix_addr_next = AW'(({22'd0, cmd_reg.page_index} * SCREEN_WIDTH)
                                        + {24'd0, cmd_reg.x_start});
                    end
                    default: state_next = ST_RD;
                endcase
            end
            ST_RD: begin
                // latch the point, step the walker or fill address; ST_WAIT issues the read
                if (cmd_reg.opcode == OP_FILL) begin
                    pix_addr_next = addr_reg[AW-1:0];
                    on_next   = 1'b1;
                    last_next = (addr_reg == CW'(DEPTH - 1));
                    addr_next = addr_reg + 1'b1;
                end else begin
                    pix_addr_next = cur_addr;
                    mask_next = 8'(1) << y_reg[2:0];
                    on_next   = cur_on;
                    last_next = (cmd_reg.opcode == OP_PIXEL) ||
                                (x_reg == 10'(cmd_reg.x_end) && y_reg == 10'(cmd_reg.y_end));
                    if (e2 >= 11'(dy_reg)) begin
                        x_next = (cmd_reg.x_start < cmd_reg.x_end) ? x_reg + 10'sd1
                                                                   : x_reg - 10'sd1;
                    end
                    err_next = err_reg + ((e2 >= 11'(dy_reg)) ? dy_reg : 10'sd0)
                                       + ((e2 <= 11'(dx_reg)) ? dx_reg : 10'sd0);
                    if (e2 <= 11'(dx_reg)) begin
                        y_next = (cmd_reg.y_start < cmd_reg.y_end) ? y_reg + 10'sd1
                                                                   : y_reg - 10'sd1;
                    end
                end
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                raddr = pix_addr_reg;
                state_next = (cmd_reg.opcode == OP_READ) ? ST_OUT : ST_WR;
            end
            ST_WR: begin
                if (on_reg) begin
                    we = 1'b1;
                    if (cmd_reg.opcode == OP_FILL) begin
                        case (cmd_reg.color)
                            COLOR_WHITE:  wdata = 8'hFF;
                            COLOR_INVERT: wdata = ~rdata;
                            default:      wdata = 8'h00;
                        endcase
                    end else begin
                        case (cmd_reg.color)
                            COLOR_BLACK: wdata = rdata & ~mask_reg;
                            COLOR_WHITE: wdata = rdata | mask_reg;
                            default:     wdata = rdata ^ mask_reg;
                        endcase
                    end
                    cnt_next = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 10'd1;
                end
                state_next = last_reg ? ST_OUT : ST_RD;
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    res_next.read_byte =
                        (cmd_reg.opcode == OP_READ && on_reg) ? rdata : 8'h00;
                    res_next.pixels_touched = cnt_reg;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            mv_reg    <= mv_next;
        end
        cmd_reg      <= cmd_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        err_reg      <= err_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        on_reg       <= on_next;
        pix_addr_reg <= pix_addr_next;
        mask_reg     <= mask_next;
        res_reg      <= res_next;
    end
endmodule
`default_nettype wire

/* src/framebuffer_line_raster_engine_core.sv */
`default_nettype none
// Monochrome page-organized framebuffer with pixel, line, fill and byte-read beats.
// Input channel s_*: one cmd_t beat per command. Result channel m_*: exactly one
// result_t beat per command, in order.
// Commands enter a two-entry queue (front end) and are executed one at a time by
// the back end, which holds the frame store in a single-port-write RAM.
// Each touched pixel or byte passes through the states read, wait and write in turn;
// a byte read passes through wait and then straight to the output state.
// After reset the back end clears the store, one byte per cycle, all
// PAGES*SCREEN_WIDTH bytes (512 by default); commands queue meanwhile.
// When the receiver stalls, the result is held in the output register; up to two
// further beats are taken into the queue before s_ready drops.
module framebuffer_line_raster_engine_core
    import flre_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 32
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire cmd_t    s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);
`include "assert_macros.svh"

    logic q_valid, q_ready, busy;
    cmd_t q_cmd;

    flre_cmd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_cmd(s_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    flre_exec #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_exec (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data), .busy(busy)
    );

    // a read never reports touched pixels
    `ASSERT_IMPLIES(a_read_zero, aclk, aresetn, m_valid && m_data.read_byte != 8'h00,
                    m_data.pixels_touched == 10'd0)
    // the back end takes a command only when idle, and is busy after it
    `ASSERT_NEXT(a_take_busy, aclk, aresetn, q_valid && q_ready, busy)
    // a stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
endmodule
`default_nettype wire
